[rtl/block_pulse_train_generator_defines.svh]
// Assertion macros used by the pulse train generator top level.
`ifndef BLOCK_PULSE_TRAIN_GENERATOR_DEFINES_SVH
`define BLOCK_PULSE_TRAIN_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BPTG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse train generator check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BPTG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse train generator check failed");

`endif

[rtl/bptg_pkg.sv]
// Shared types and constants of the pulse train generator.
package bptg_pkg;

  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam int MAX_TIME_WIDTH     = 48;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_DELAY,
    PH_HIGH,
    PH_LOW,
    PH_OFF
  } phase_t;

  typedef logic [2:0] reg_index_t;

  localparam reg_index_t REG_START_DELAY = 3'd0;
  localparam reg_index_t REG_HIGH_US     = 3'd1;
  localparam reg_index_t REG_LOW_US      = 3'd2;
  localparam reg_index_t REG_PULSES      = 3'd3;
  localparam reg_index_t REG_OFF_US      = 3'd4;
  localparam reg_index_t REG_BLOCK_COUNT = 3'd5;
  localparam reg_index_t REG_TRIG_ENABLE = 3'd6;

  localparam logic [23:0] PULSE_TIME_RESET = 24'd1;

  typedef struct packed {
    logic [31:0] start_delay_us;
    logic [23:0] high_us;
    logic [23:0] low_us;
    logic [15:0] pulses_per_block;
    logic [31:0] off_us;
    logic [15:0] block_count;
    logic        trig_enable;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] pulse_index;
    logic [15:0] block_index;
    logic        first;
  } ctrl_t;

  typedef struct packed {
    logic        ttl_level;
    logic        rising_edge;
    logic [15:0] pulse_number;
    logic [15:0] block_number;
    logic [31:0] elapsed_us;
    logic        busy_res;
    logic        run_done;
  } result_t;

endpackage

[rtl/block_pulse_train_generator.sv]
// Top level of the triggered burst pulse train generator.
// Each input item is one microsecond tick and produces exactly one result item
// on the next clock. An item is taken on every clock in which the result
// register is empty or being drained, so the sustained rate is one item per
// clock while the output does not stall. Runs are to be programmed through
// the write port while idle (not enforced): start delay, pulse high and low
// times, pulses per block, off time after each block, block count and trigger
// enable. Segment times and the elapsed count saturate at TIME_WIDTH bits.
module block_pulse_train_generator #(
  parameter int TIME_WIDTH = bptg_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic        trigger_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ttl_level,
  output logic        rising_edge,
  output logic [15:0] pulse_number,
  output logic [15:0] block_number,
  output logic [31:0] elapsed_us,
  output logic        busy_res,
  output logic        run_done
);

  `include "block_pulse_train_generator_defines.svh"

  bptg_pkg::cfg_t        cfg;
  bptg_pkg::ctrl_t       ctrl;
  bptg_pkg::ctrl_t       ctrl_next;
  logic [TIME_WIDTH-1:0] remaining;
  logic [TIME_WIDTH-1:0] remaining_next;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH-1:0] elapsed_next;
  bptg_pkg::result_t     result;
  bptg_pkg::result_t     result_next;
  logic                  accept;
  logic                  ctrl_timed;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay_us   <= '0;
      cfg.high_us          <= bptg_pkg::PULSE_TIME_RESET;
      cfg.low_us           <= bptg_pkg::PULSE_TIME_RESET;
      cfg.pulses_per_block <= '0;
      cfg.off_us           <= '0;
      cfg.block_count      <= '0;
      cfg.trig_enable      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        bptg_pkg::REG_START_DELAY: cfg.start_delay_us   <= cfg_data;
        bptg_pkg::REG_HIGH_US:     cfg.high_us          <= cfg_data[23:0];
        bptg_pkg::REG_LOW_US:      cfg.low_us           <= cfg_data[23:0];
        bptg_pkg::REG_PULSES:      cfg.pulses_per_block <= cfg_data[15:0];
        bptg_pkg::REG_OFF_US:      cfg.off_us           <= cfg_data;
        bptg_pkg::REG_BLOCK_COUNT: cfg.block_count      <= cfg_data[15:0];
        bptg_pkg::REG_TRIG_ENABLE: cfg.trig_enable      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  bptg_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .cfg            (cfg),
    .ctrl           (ctrl),
    .remaining      (remaining),
    .elapsed        (elapsed),
    .start_req      (start_req),
    .trigger_level  (trigger_level),
    .ctrl_next      (ctrl_next),
    .remaining_next (remaining_next),
    .elapsed_next   (elapsed_next),
    .result         (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase       <= bptg_pkg::PH_IDLE;
      ctrl.pulse_index <= '0;
      ctrl.block_index <= '0;
      ctrl.first       <= 1'b0;
      remaining        <= '0;
      elapsed          <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        ctrl      <= ctrl_next;
        remaining <= remaining_next;
        elapsed   <= elapsed_next;
      end
      out_valid <= accept || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign ttl_level    = result.ttl_level;
  assign rising_edge  = result.rising_edge;
  assign pulse_number = result.pulse_number;
  assign block_number = result.block_number;
  assign elapsed_us   = result.elapsed_us;
  assign busy_res     = result.busy_res;
  assign run_done     = result.run_done;

  assign ctrl_timed = (ctrl.phase == bptg_pkg::PH_DELAY) || (ctrl.phase == bptg_pkg::PH_HIGH) ||
                      (ctrl.phase == bptg_pkg::PH_LOW) || (ctrl.phase == bptg_pkg::PH_OFF);

  // A timed segment always has at least one tick left.
  `BPTG_ASSERT_IMP(a_timed_nonzero, ctrl_timed, remaining != '0)
  `BPTG_ASSERT_IMP(a_rise_is_high, out_valid && rising_edge, ttl_level)
  `BPTG_ASSERT_IMP(a_idle_quiet, out_valid && !busy_res, !ttl_level && !run_done)
  `BPTG_ASSERT_NXT(a_accept_shows, accept, out_valid)

endmodule

[rtl/bptg_step.sv]
// Next-state and result logic for one microsecond tick of the pulse train generator.
module bptg_step #(
  parameter int TIME_WIDTH = bptg_pkg::TIME_WIDTH_DEFAULT
) (
  input  bptg_pkg::cfg_t          cfg,
  input  bptg_pkg::ctrl_t         ctrl,
  input  logic [TIME_WIDTH-1:0]   remaining,
  input  logic [TIME_WIDTH-1:0]   elapsed,
  input  logic                    start_req,
  input  logic                    trigger_level,
  output bptg_pkg::ctrl_t         ctrl_next,
  output logic [TIME_WIDTH-1:0]   remaining_next,
  output logic [TIME_WIDTH-1:0]   elapsed_next,
  output bptg_pkg::result_t       result
);

  localparam int WIDE = bptg_pkg::MAX_TIME_WIDTH;

  typedef struct packed {
    bptg_pkg::phase_t        phase;
    logic [TIME_WIDTH-1:0]   remaining;
    logic [15:0]             pulse_index;
    logic [15:0]             block_index;
    logic                    first;
  } seg_t;

  logic [TIME_WIDTH-1:0] delay_len;
  logic [TIME_WIDTH-1:0] high_len;
  logic [TIME_WIDTH-1:0] low_len;
  logic [TIME_WIDTH-1:0] off_len;
  logic [TIME_WIDTH-1:0] elapsed_start;
  seg_t                  seg_cur;
  seg_t                  seg_start;
  seg_t                  seg_next;
  logic                  begin_run;
  logic                  timed;

  // Segment lengths saturate at the time width.
  function automatic logic [TIME_WIDTH-1:0] clamp_time(input logic [31:0] v);
    logic [TIME_WIDTH-1:0] r;
    if ((WIDE'(v) >> TIME_WIDTH) != '0) begin
      r = '1;
    end else begin
      r = TIME_WIDTH'(v);
    end
    return r;
  endfunction

  function automatic seg_t block_begin(input logic [15:0] bidx);
    seg_t s;
    s.phase       = bptg_pkg::PH_IDLE;
    s.remaining   = '0;
    s.pulse_index = '0;
    s.block_index = bidx;
    s.first       = 1'b0;
    if (bidx >= cfg.block_count) begin
      s.phase = bptg_pkg::PH_IDLE;
    end else if (cfg.pulses_per_block != '0) begin
      s.phase     = bptg_pkg::PH_HIGH;
      s.remaining = high_len;
      s.first     = 1'b1;
    end else if (cfg.off_us != '0) begin
      s.phase     = bptg_pkg::PH_OFF;
      s.remaining = off_len;
      s.first     = 1'b1;
    end else begin
      // Blocks without pulses or off time: the run ends right after the delay.
      s.block_index = cfg.block_count;
    end
    return s;
  endfunction

  // Leave a segment whose count has run out. Every segment loaded here is at
  // least one tick long, so one step always settles.
  function automatic seg_t expire(input seg_t s);
    seg_t        r;
    logic [15:0] pnext;
    logic [15:0] bnext;
    r     = s;
    pnext = s.pulse_index + 16'd1;
    bnext = s.block_index + 16'd1;
    case (s.phase)
      bptg_pkg::PH_DELAY: begin
        r = block_begin(16'd0);
      end
      bptg_pkg::PH_HIGH: begin
        r.phase     = bptg_pkg::PH_LOW;
        r.remaining = low_len;
        r.first     = 1'b1;
      end
      bptg_pkg::PH_LOW: begin
        r.pulse_index = pnext;
        if (pnext < cfg.pulses_per_block) begin
          r.phase     = bptg_pkg::PH_HIGH;
          r.remaining = high_len;
          r.first     = 1'b1;
        end else if (cfg.off_us != '0) begin
          r.phase     = bptg_pkg::PH_OFF;
          r.remaining = off_len;
          r.first     = 1'b1;
        end else begin
          r = block_begin(bnext);
        end
      end
      bptg_pkg::PH_OFF: begin
        r = block_begin(bnext);
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  assign delay_len = clamp_time(cfg.start_delay_us);
  assign off_len   = clamp_time(cfg.off_us);
  assign high_len  = clamp_time({8'd0, (cfg.high_us == '0) ? 24'd1 : cfg.high_us});
  assign low_len   = clamp_time({8'd0, (cfg.low_us == '0) ? 24'd1 : cfg.low_us});

  always_comb begin
    seg_cur.phase       = ctrl.phase;
    seg_cur.remaining   = remaining;
    seg_cur.pulse_index = ctrl.pulse_index;
    seg_cur.block_index = ctrl.block_index;
    seg_cur.first       = ctrl.first;

    begin_run = ((ctrl.phase == bptg_pkg::PH_IDLE) && start_req &&
                 (!cfg.trig_enable || trigger_level)) ||
                ((ctrl.phase == bptg_pkg::PH_WAIT) && trigger_level);

    seg_start     = seg_cur;
    elapsed_start = elapsed;
    if (begin_run) begin
      seg_start.phase       = bptg_pkg::PH_DELAY;
      seg_start.remaining   = delay_len;
      seg_start.pulse_index = '0;
      seg_start.block_index = '0;
      seg_start.first       = 1'b1;
      elapsed_start         = '0;
      if (delay_len == '0) begin
        seg_start = expire(seg_start);
      end
    end else if ((ctrl.phase == bptg_pkg::PH_IDLE) && start_req) begin
      seg_start.phase = bptg_pkg::PH_WAIT;
    end

    timed = (seg_start.phase == bptg_pkg::PH_DELAY) || (seg_start.phase == bptg_pkg::PH_HIGH) ||
            (seg_start.phase == bptg_pkg::PH_LOW) || (seg_start.phase == bptg_pkg::PH_OFF);

    result       = '0;
    seg_next     = seg_start;
    elapsed_next = elapsed_start;
    if (timed) begin
      result.ttl_level    = seg_start.phase == bptg_pkg::PH_HIGH;
      result.rising_edge  = (seg_start.phase == bptg_pkg::PH_HIGH) && seg_start.first;
      result.pulse_number = seg_start.pulse_index;
      result.block_number = seg_start.block_index;
      if ((WIDE'(elapsed_start) >> 32) != '0) begin
        result.elapsed_us = '1;
      end else begin
        result.elapsed_us = 32'(elapsed_start);
      end
      result.busy_res     = 1'b1;
      seg_next.first      = 1'b0;
      seg_next.remaining  = seg_start.remaining - TIME_WIDTH'(1);
      if (elapsed_start != '1) begin
        elapsed_next = elapsed_start + TIME_WIDTH'(1);
      end
      if (seg_next.remaining == '0) begin
        seg_next        = expire(seg_next);
        result.run_done = seg_next.phase == bptg_pkg::PH_IDLE;
      end
    end else if (begin_run) begin
      result.busy_res = 1'b1;
      result.run_done = 1'b1;
    end else if (seg_start.phase == bptg_pkg::PH_WAIT) begin
      result.busy_res = 1'b1;
    end

    ctrl_next.phase       = seg_next.phase;
    ctrl_next.pulse_index = seg_next.pulse_index;
    ctrl_next.block_index = seg_next.block_index;
    ctrl_next.first       = seg_next.first;
    remaining_next        = seg_next.remaining;
  end

endmodule

[dv/tb.sv]
// Self-checking testbench for the triggered burst pulse train generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    bptg_pkg::reg_index_t idx;
    logic [31:0]          val;
    bit                   s;
    bit                   t;
    bit                   typed;
    bptg_pkg::result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        start_req = 1'b0;
  logic        trigger_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        ttl_level;
  logic        rising_edge;
  logic [15:0] pulse_number;
  logic [15:0] block_number;
  logic [31:0] elapsed_us;
  logic        busy_res;
  logic        run_done;

  block_pulse_train_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_req    (start_req),
    .trigger_level(trigger_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ttl_level    (ttl_level),
    .rising_edge  (rising_edge),
    .pulse_number (pulse_number),
    .block_number (block_number),
    .elapsed_us   (elapsed_us),
    .busy_res     (busy_res),
    .run_done     (run_done)
  );

  // Predictor copy of the registers and the run state.
  logic [31:0]      c_delay, c_off;
  logic [23:0]      c_high, c_low;
  logic [15:0]      c_pulses, c_blocks;
  logic             c_trig;
  bptg_pkg::phase_t ph;
  logic [31:0]      rem;
  int unsigned      pcnt, bcnt;
  logic [31:0]      elapsed;
  bit               first;

  bptg_pkg::result_t tick_results_due[$];
  stim_row_t         rows[$];
  int                err_count = 0;
  int                tx_calm = 0;
  int                rx_calm = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int gap_draw(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic void load_segment(bptg_pkg::phase_t p, logic [31:0] len);
    ph = p;
    rem = len;
    first = 1'b1;
  endfunction

  function automatic void end_run();
    ph = bptg_pkg::PH_IDLE;
    rem = '0;
    first = 1'b0;
  endfunction

  function automatic void load_high();
    load_segment(bptg_pkg::PH_HIGH, (c_high == 0) ? 32'd1 : {8'd0, c_high});
  endfunction

  function automatic void open_block();
    pcnt = 0;
    if (bcnt >= c_blocks) begin
      end_run();
    end else if (c_pulses != 0) begin
      load_high();
    end else if (c_off != 0) begin
      load_segment(bptg_pkg::PH_OFF, c_off);
    end else begin
      bcnt = 32'(c_blocks);
      end_run();
    end
  endfunction

  function automatic bit is_timed();
    return ph == bptg_pkg::PH_DELAY || ph == bptg_pkg::PH_HIGH ||
           ph == bptg_pkg::PH_LOW || ph == bptg_pkg::PH_OFF;
  endfunction

  // Walks through every segment that has run out, including zero-length ones.
  function automatic void step_segments();
    while (is_timed() && rem == 0) begin
      case (ph)
        bptg_pkg::PH_DELAY: begin
          bcnt = 0;
          open_block();
        end
        bptg_pkg::PH_HIGH: begin
          load_segment(bptg_pkg::PH_LOW, (c_low == 0) ? 32'd1 : {8'd0, c_low});
        end
        bptg_pkg::PH_LOW: begin
          pcnt++;
          if (pcnt < c_pulses) begin
            load_high();
          end else if (c_off != 0) begin
            load_segment(bptg_pkg::PH_OFF, c_off);
          end else begin
            bcnt++;
            open_block();
          end
        end
        default: begin
          bcnt++;
          open_block();
        end
      endcase
    end
  endfunction

  function automatic void start_timing();
    elapsed = '0;
    pcnt = 0;
    bcnt = 0;
    load_segment(bptg_pkg::PH_DELAY, c_delay);
    step_segments();
  endfunction

  function automatic bptg_pkg::result_t predict_tick(bit s, bit t);
    bptg_pkg::result_t r;
    bit                started;
    r = '0;
    started = 1'b0;
    if (ph == bptg_pkg::PH_IDLE && s) begin
      if (c_trig) begin
        ph = bptg_pkg::PH_WAIT;
      end else begin
        start_timing();
        started = 1'b1;
      end
    end
    if (ph == bptg_pkg::PH_WAIT && t) begin
      start_timing();
      started = 1'b1;
    end
    if (is_timed()) begin
      r.ttl_level = (ph == bptg_pkg::PH_HIGH);
      r.rising_edge = (ph == bptg_pkg::PH_HIGH) && first;
      r.pulse_number = pcnt[15:0];
      r.block_number = bcnt[15:0];
      r.elapsed_us = elapsed;
      r.busy_res = 1'b1;
      first = 1'b0;
      rem = rem - 32'd1;
      if (elapsed != '1) elapsed = elapsed + 32'd1;
      if (rem == 0) begin
        step_segments();
        if (ph == bptg_pkg::PH_IDLE) r.run_done = 1'b1;
      end
    end else if (started) begin
      r.busy_res = 1'b1;
      r.run_done = 1'b1;
    end else if (ph == bptg_pkg::PH_WAIT) begin
      r.busy_res = 1'b1;
    end
    return r;
  endfunction

  function automatic bptg_pkg::result_t status_only(bit busy, bit done);
    bptg_pkg::result_t r;
    r = '0;
    r.busy_res = busy;
    r.run_done = done;
    return r;
  endfunction

  function automatic stim_row_t tick_row(bit s, bit t);
    stim_row_t r;
    r = '{ROW_TICK, bptg_pkg::REG_START_DELAY, 32'd0, s, t, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(bit s, bit t, bptg_pkg::result_t w);
    stim_row_t r;
    r = '{ROW_TICK, bptg_pkg::REG_START_DELAY, 32'd0, s, t, 1'b1, w};
    return r;
  endfunction

  function automatic stim_row_t write_row(bptg_pkg::reg_index_t idx, logic [31:0] val);
    stim_row_t r;
    r = '{ROW_WRITE, idx, val, 1'b0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Sends one tick item and queues what it should produce once it is taken.
  task automatic put_tick(bit s, bit t, bit typed, bptg_pkg::result_t want);
    int                gap;
    bptg_pkg::result_t r;
    gap = gap_draw(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_req <= s;
    trigger_level <= t;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = predict_tick(s, t);
    tick_results_due.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Lets any run in progress finish, firing the trigger if one is awaited.
  task automatic settle_run();
    int n;
    n = 0;
    while (ph != bptg_pkg::PH_IDLE && n < 4000) begin
      put_tick(1'b0, ph == bptg_pkg::PH_WAIT, 1'b0, '0);
      n++;
    end
    wait_drained();
  endtask

  task automatic write_reg(bptg_pkg::reg_index_t idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bptg_pkg::REG_START_DELAY: c_delay = val;
      bptg_pkg::REG_HIGH_US:     c_high = val[23:0];
      bptg_pkg::REG_LOW_US:      c_low = val[23:0];
      bptg_pkg::REG_PULSES:      c_pulses = val[15:0];
      bptg_pkg::REG_OFF_US:      c_off = val;
      bptg_pkg::REG_BLOCK_COUNT: c_blocks = val[15:0];
      bptg_pkg::REG_TRIG_ENABLE: c_trig = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    bptg_pkg::result_t want;
    int                w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = gap_draw(rx_calm);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (tick_results_due.size() == 0) begin
        report_mismatch("result item arrived with nothing expected");
      end else begin
        want = tick_results_due.pop_front();
        check_field("ttl_level", 32'(ttl_level), 32'(want.ttl_level));
        check_field("rising_edge", 32'(rising_edge), 32'(want.rising_edge));
        check_field("pulse_number", 32'(pulse_number), 32'(want.pulse_number));
        check_field("block_number", 32'(block_number), 32'(want.block_number));
        check_field("elapsed_us", elapsed_us, want.elapsed_us);
        check_field("busy_res", 32'(busy_res), 32'(want.busy_res));
        check_field("run_done", 32'(run_done), 32'(want.run_done));
      end
    end
  end

  initial begin
    int p;
    c_delay = '0;
    c_high = bptg_pkg::PULSE_TIME_RESET;
    c_low = bptg_pkg::PULSE_TIME_RESET;
    c_pulses = '0;
    c_off = '0;
    c_blocks = '0;
    c_trig = 1'b0;
    ph = bptg_pkg::PH_IDLE;
    rem = '0;
    pcnt = 0;
    bcnt = 0;
    elapsed = '0;
    first = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // With the reset settings a start is a one-tick run that is busy and done.
    rows.push_back(typed_row(1'b0, 1'b0, status_only(1'b0, 1'b0)));
    rows.push_back(typed_row(1'b1, 1'b0, status_only(1'b1, 1'b1)));
    rows.push_back(typed_row(1'b0, 1'b1, status_only(1'b0, 1'b0)));
    rows.push_back(write_row(bptg_pkg::REG_TRIG_ENABLE, 32'd1));
    rows.push_back(typed_row(1'b1, 1'b0, status_only(1'b1, 1'b0)));
    rows.push_back(typed_row(1'b1, 1'b0, status_only(1'b1, 1'b0)));
    rows.push_back(typed_row(1'b0, 1'b1, status_only(1'b1, 1'b1)));
    // Zero high and low times act as one tick.
    rows.push_back(write_row(bptg_pkg::REG_START_DELAY, 32'd2));
    rows.push_back(write_row(bptg_pkg::REG_HIGH_US, 32'd0));
    rows.push_back(write_row(bptg_pkg::REG_LOW_US, 32'd0));
    rows.push_back(write_row(bptg_pkg::REG_PULSES, 32'd2));
    rows.push_back(write_row(bptg_pkg::REG_OFF_US, 32'd3));
    rows.push_back(write_row(bptg_pkg::REG_BLOCK_COUNT, 32'd2));
    rows.push_back(tick_row(1'b1, 1'b1));
    rows.push_back(tick_row(1'b1, 1'b0));
    // Blocks with neither pulses nor off time leave only the start delay.
    rows.push_back(write_row(bptg_pkg::REG_PULSES, 32'd0));
    rows.push_back(write_row(bptg_pkg::REG_OFF_US, 32'd0));
    rows.push_back(write_row(bptg_pkg::REG_TRIG_ENABLE, 32'd0));
    rows.push_back(tick_row(1'b1, 1'b0));
    rows.push_back(write_row(bptg_pkg::REG_START_DELAY, 32'd0));
    rows.push_back(typed_row(1'b1, 1'b0, status_only(1'b1, 1'b1)));
    rows.push_back(write_row(bptg_pkg::REG_OFF_US, 32'd2));
    rows.push_back(tick_row(1'b1, 1'b0));
    rows.push_back(write_row(bptg_pkg::REG_HIGH_US, 32'd3));
    rows.push_back(write_row(bptg_pkg::REG_LOW_US, 32'd2));
    rows.push_back(write_row(bptg_pkg::REG_PULSES, 32'd1));
    rows.push_back(tick_row(1'b1, 1'b0));
    rows.push_back(tick_row(1'b0, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        settle_run();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        put_tick(rows[i].s, rows[i].t, rows[i].typed, rows[i].want);
      end
    end

    // Small random settings keep runs short; unused upper data bits are noise.
    for (p = 0; p < 8; p++) begin
      settle_run();
      write_reg(bptg_pkg::REG_START_DELAY, $urandom_range(0, 12));
      write_reg(bptg_pkg::REG_HIGH_US, ($urandom & 32'hFF00_0000) | $urandom_range(0, 6));
      write_reg(bptg_pkg::REG_LOW_US, ($urandom & 32'hFF00_0000) | $urandom_range(0, 6));
      write_reg(bptg_pkg::REG_PULSES, ($urandom & 32'hFFFF_0000) | $urandom_range(0, 5));
      write_reg(bptg_pkg::REG_OFF_US, $urandom_range(0, 12));
      write_reg(bptg_pkg::REG_BLOCK_COUNT,
                ($urandom & 32'hFFFF_0000) | $urandom_range(0, 4));
      write_reg(bptg_pkg::REG_TRIG_ENABLE,
                ($urandom & 32'hFFFF_FFFE) | $urandom_range(0, 1));
      repeat (120)
        put_tick($urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0, 1'b0, '0);
    end

    // Largest settings: the run stays in its first long pulse to the end.
    settle_run();
    write_reg(bptg_pkg::REG_START_DELAY, 32'd0);
    write_reg(bptg_pkg::REG_HIGH_US, 32'h00FF_FFFF);
    write_reg(bptg_pkg::REG_LOW_US, 32'h00FF_FFFF);
    write_reg(bptg_pkg::REG_PULSES, 32'h0000_FFFF);
    write_reg(bptg_pkg::REG_OFF_US, 32'hFFFF_FFFF);
    write_reg(bptg_pkg::REG_BLOCK_COUNT, 32'h0000_FFFF);
    write_reg(bptg_pkg::REG_TRIG_ENABLE, 32'd1);
    put_tick(1'b1, 1'b1, 1'b0, '0);
    repeat (20)
      put_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, 1'b0, '0);
    // The delay register is only read when a run begins, so this has no effect yet.
    wait_drained();
    write_reg(bptg_pkg::REG_START_DELAY, 32'hFFFF_FFFF);
    repeat (20)
      put_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, 1'b0, '0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
